// ===== rtl/http_method_name_matcher_top_defines.svh =====
// assertion macros for the http method name matcher
`ifndef HTTP_METHOD_NAME_MATCHER_TOP_DEFINES_SVH
`define HTTP_METHOD_NAME_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define HMM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hmm assertion failed");

// checked at every edge, reset included
`define HMM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hmm assertion failed");

`else

`define HMM_ASSERT(lbl, prop)
`define HMM_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/hmm_pkg.sv =====
// constants, method name table and helpers for the http method name matcher
package hmm_pkg;

  localparam int unsigned TABLE_ROWS   = 27;
  localparam int unsigned MAX_NAME_LEN = 11;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned CODE_W       = 5;
  localparam int unsigned STR_W        = 8 * MAX_NAME_LEN;

  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_NAME_LEN);

  localparam logic [7:0] CHR_NUL     = 8'h00;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [STR_W-1:0]  name_str_t;

  // names are right-justified, first character in the highest used byte
  localparam name_str_t NAME_STR [TABLE_ROWS] = '{
    "DELETE", "GET", "HEAD", "POST", "PUT", "CONNECT", "OPTIONS", "TRACE",
    "COPY", "LOCK", "MKCOL", "MOVE", "PROPFIND", "PROPPATCH", "SEARCH",
    "UNLOCK", "REPORT", "MKACTIVITY", "CHECKOUT", "MERGE", "M-SEARCH",
    "NOTIFY", "SUBSCRIBE", "UNSUBSCRIBE", "PATCH", "PURGE", "MKCALENDAR"
  };

  localparam int unsigned NAME_LEN [TABLE_ROWS] = '{
    6, 3, 4, 4, 3, 7, 7, 5, 4, 4, 5, 4, 8, 9, 6, 6, 6, 10, 8, 5, 8, 6, 9,
    11, 5, 5, 10
  };

  // character of a table row at a position, zero past the end of the name
  function automatic logic [7:0] name_char(input int unsigned row, input pos_t pos);
    name_str_t   s;
    int unsigned len;
    s   = NAME_STR[row];
    len = NAME_LEN[row];
    if (32'(pos) < len) begin
      name_char = 8'(s >> (8 * (len - 1 - 32'(pos))));
    end else begin
      name_char = CHR_NUL;
    end
  endfunction

  // only ascii letters fold; the table holds upper case only
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
      fold_case = c - CASE_OFFSET;
    end else begin
      fold_case = c;
    end
  endfunction

endpackage

// ===== rtl/http_method_name_matcher_top.sv =====
// http method name matcher: byte input register, match mask and result register
//
//   channel | handshake                   | payload
//   --------+-----------------------------+-------------------------------
//   in      | in_valid_i / in_stall_o     | name_byte_i
//   out     | out_valid_o / out_stall_i   | found_o, method_code_o
//
// one byte per cycle while in_stall_o is low; a byte waits in the input
// register and the mask update runs from there; out_valid_o is registered
// when the terminator fires out of the input register.
// reset gives an empty pipeline, a full match mask and position zero.
// a stalled result holds only a terminator in the input register; name bytes
// keep flowing while the result waits.
`include "http_method_name_matcher_top_defines.svh"

module http_method_name_matcher_top
  import hmm_pkg::*;
#(
  parameter int unsigned NAME_COUNT = 27
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        name_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic [CODE_W-1:0] method_code_o
);

  localparam int unsigned ROWS = (NAME_COUNT > TABLE_ROWS) ? TABLE_ROWS : NAME_COUNT;

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic [ROWS-1:0] mask_q, mask_d;
  pos_t            pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  code_t           code_q, code_d;

  logic            out_free;
  logic            is_term;
  logic            fire;
  logic [7:0]      byte_fold;
  logic [ROWS-1:0] row_ok;
  logic [ROWS-1:0] row_end;
  logic            len_ok;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_term   = (in_byte_q == CHR_NUL);
  assign fire      = in_valid_q && (!is_term || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign byte_fold = fold_case(in_byte_q);
  assign len_ok    = (pos_q != '0) && (pos_q <= POS_LIMIT);

  // per-row compare against the table character at the current position
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [7:0] tc;
    assign tc         = name_char(r, pos_q);
    assign row_ok[r]  = (tc != CHR_NUL) && (tc == byte_fold);
    assign row_end[r] = mask_q[r] && (tc == CHR_NUL);
  end

  always_comb begin
    mask_d = mask_q;
    pos_d  = pos_q;
    if (fire) begin
      if (is_term) begin
        mask_d = '1;
        pos_d  = '0;
      end else begin
        if (pos_q >= POS_LIMIT) begin
          mask_d = '0;
        end else begin
          mask_d = mask_q & row_ok;
        end
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    found_d = 1'b0;
    code_d  = '0;
    // lowest code wins, walked from the top down
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (len_ok && row_end[i]) begin
        found_d = 1'b1;
        code_d  = CODE_W'(i);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = fire && is_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= '1;
      pos_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= name_byte_i;
    end
    if (out_free && fire && is_term) begin
      found_q <= found_d;
      code_q  <= code_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign method_code_o = code_q;

  // only a waiting terminator behind a stalled result can block the input
  `HMM_ASSERT(a_stall_cause, in_stall_o |-> (in_valid_q && is_term && out_valid_q && out_stall_i))
  // a terminator puts the match state back to its reset value
  `HMM_ASSERT(a_term_restart, (fire && is_term) |=> (pos_q == '0 && mask_q == '1))
  // an overlong name kills every row
  `HMM_ASSERT(a_too_long, (fire && !is_term && pos_q >= POS_LIMIT) |=> (mask_q == '0))
  // a found code lies in the table; a miss reports code zero
  `HMM_ASSERT(a_code_range, (out_valid_q && found_q) |-> (32'(code_q) < ROWS))
  `HMM_ASSERT(a_miss_code, (out_valid_q && !found_q) |-> (code_q == '0))
  // a clock edge in reset is followed by no valid result and no input stall
  `HMM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && !in_stall_o))

endmodule

// ===== sim/http_method_name_matcher_top_tb.sv =====
// testbench for the http method name matcher: byte stream in, match result out
module http_method_name_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned METHOD_COUNT = 27;
  localparam int unsigned LONGEST_NAME = 11;
  localparam logic [3:0]  POS_SAT      = 4'hf;
  localparam logic [7:0]  TERMINATOR   = 8'h00;

  typedef struct packed {
    logic                       found;
    logic [hmm_pkg::CODE_W-1:0] code;
  } method_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 name_byte_i = 8'h00;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       found_o;
  logic [hmm_pkg::CODE_W-1:0] method_code_o;

  http_method_name_matcher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .name_byte_i   (name_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .method_code_o (method_code_o)
  );

  string method_names [METHOD_COUNT] = '{
    "DELETE", "GET", "HEAD", "POST", "PUT", "CONNECT", "OPTIONS", "TRACE",
    "COPY", "LOCK", "MKCOL", "MOVE", "PROPFIND", "PROPPATCH", "SEARCH",
    "UNLOCK", "REPORT", "MKACTIVITY", "CHECKOUT", "MERGE", "M-SEARCH",
    "NOTIFY", "SUBSCRIBE", "UNSUBSCRIBE", "PATCH", "PURGE", "MKCALENDAR"
  };

  logic [7:0]     pending_bytes [$];
  method_result_t expected_results [$];
  int             mismatch_count = 0;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             send_calm = 0;
  int             stall_calm = 0;

  // matcher state as seen by the predictor
  logic [METHOD_COUNT-1:0] live_names = '1;
  logic [3:0]              name_pos = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] table_char(input int row, input int pos);
    if (pos < method_names[row].len()) begin
      return method_names[row][pos];
    end
    return TERMINATOR;
  endfunction

  // advances the predictor by one byte; a terminator yields a result
  function automatic bit step_matcher(input logic [7:0] b, output method_result_t res);
    res = '0;
    if (b != TERMINATOR) begin
      if (name_pos >= LONGEST_NAME) begin
        live_names = '0;
      end else begin
        for (int i = 0; i < METHOD_COUNT; i++) begin
          if (table_char(i, name_pos) == TERMINATOR ||
              upper_of(table_char(i, name_pos)) != upper_of(b)) begin
            live_names[i] = 1'b0;
          end
        end
      end
      if (name_pos != POS_SAT) begin
        name_pos = name_pos + 4'd1;
      end
      return 1'b0;
    end
    if (name_pos > 0 && name_pos <= LONGEST_NAME) begin
      for (int i = 0; i < METHOD_COUNT; i++) begin
        if (live_names[i] && table_char(i, name_pos) == TERMINATOR && !res.found) begin
          res.found = 1'b1;
          res.code  = hmm_pkg::CODE_W'(i);
        end
      end
    end
    live_names = '1;
    name_pos   = '0;
    return 1'b1;
  endfunction

  // driver: holds a stalled item, predicts on each accepted one
  always @(posedge clk_i) begin : drive_names
    method_result_t res;
    bit             go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (step_matcher(name_byte_i, res)) begin
          expected_results.push_back(res);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_calm > 0) begin
          send_calm--;
        end else if ($urandom_range(99) == 0) begin
          send_calm = $urandom_range(60, 20);
        end
        go = pending_bytes.size() > 0 &&
             (send_calm > 0 || $urandom_range(99) >= send_idle_pct);
        if (go) begin
          in_valid_i  <= 1'b1;
          name_byte_i <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, compares each accepted result with the oldest expected one
  always @(posedge clk_i) begin : check_results
    method_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: found %0d, method_code %0d", found_o, method_code_o);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_o);
            mismatch_count++;
          end
          if (method_code_o !== want.code) begin
            $error("method_code: expected %0d, actual %0d", want.code, method_code_o);
            mismatch_count++;
          end
        end
      end
      if (stall_calm > 0) begin
        stall_calm--;
      end else if ($urandom_range(99) == 0) begin
        stall_calm = $urandom_range(60, 20);
      end
      out_stall_i <= stall_calm == 0 && $urandom_range(99) < stall_pct;
    end
  end

  task automatic queue_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) pending_bytes.push_back(seq[i]);
    pending_bytes.push_back(TERMINATOR);
  endtask

  function automatic void text_to_bytes(input string s, input bit mix_case,
                                        ref logic [7:0] seq [$]);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= 8'h41 && c <= 8'h5a && $urandom_range(1)) begin
        c = c + 8'h20;
      end
      seq.push_back(c);
    end
  endfunction

  task automatic queue_text(input string s, input bit mix_case);
    logic [7:0] seq [$];
    text_to_bytes(s, mix_case, seq);
    queue_bytes(seq);
  endtask

  // mostly real method names with random case, then prefixes, overlong and corrupted names, and random byte strings
  task automatic queue_random_name();
    logic [7:0] seq [$];
    int         kind;
    int         row;
    int         cut;
    kind = $urandom_range(99);
    row  = $urandom_range(METHOD_COUNT - 1);
    if (kind < 88) begin
      text_to_bytes(method_names[row], 1'b1, seq);
    end
    if (kind < 60) begin
      // name as is
    end else if (kind < 70) begin
      cut = $urandom_range(seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
    end else if (kind < 78) begin
      repeat ($urandom_range(6, 1)) seq.push_back(8'($urandom_range(8'h5a, 8'h41)));
    end else if (kind < 88) begin
      seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255, 1));
    end else begin
      repeat ($urandom_range(20)) seq.push_back(8'($urandom_range(255, 1)));
    end
    queue_bytes(seq);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid_i || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [7:0] seq [$];
    int         phase_start;
    int         sent_total;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every method, case folding, empty, prefix, too long, odd bytes
    foreach (method_names[i]) queue_text(method_names[i], 1'b0);
    queue_text("get", 1'b0);
    queue_text("m-SeArCh", 1'b0);
    queue_text("", 1'b0);
    queue_text("GE", 1'b0);
    queue_text("GETS", 1'b0);
    queue_text("UNSUBSCRIBES", 1'b0);
    queue_text("MKCALENDARMKCALENDAR", 1'b0);
    seq = {8'h47, 8'hff, 8'h54};
    queue_bytes(seq);
    seq = {8'h60, 8'h45, 8'h54};
    queue_bytes(seq);
    seq = {8'hc7, 8'hc5, 8'hd4};
    queue_bytes(seq);
    wait_drained();

    sent_total = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      phase_start = sent_total;
      while (sent_total - phase_start < 185) begin
        sent_total -= pending_bytes.size();
        queue_random_name();
        sent_total += pending_bytes.size();
      end
      // sender holds off until every result of this phase is back
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
